// ===== hdl/assert_macros.svh =====
// assertion macros used by the top-level rtl file of the int8 vector alu
// no dependencies; the including module supplies clk and rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// also checked across reset
`define ASSERT_CLK_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/isva_pkg.sv =====
// shared types and constants of the int8 saturating vector alu
// no dependencies
package isva_pkg;

  typedef enum logic [4:0] {
    OP_ADD            = 5'd0,
    OP_ADDSCALAR      = 5'd1,
    OP_SUB            = 5'd2,
    OP_ABS            = 5'd3,
    OP_NEG            = 5'd4,
    OP_CEIL           = 5'd5,
    OP_FLOOR          = 5'd6,
    OP_EQ             = 5'd7,
    OP_GT             = 5'd8,
    OP_LT             = 5'd9,
    OP_MULWIDE        = 5'd10,
    OP_MULSHIFT       = 5'd11,
    OP_MULSCALARSHIFT = 5'd12,
    OP_RELU           = 5'd13,
    OP_DOT            = 5'd14,
    OP_SUM            = 5'd15,
    OP_MAC            = 5'd16,
    OP_ZERO           = 5'd17
  } op_t;

  typedef enum logic [2:0] {
    REG_SCALAR  = 3'd0,
    REG_MULT    = 3'd1,
    REG_SHIFT   = 3'd2,
    REG_CEILING = 3'd3,
    REG_FLOOR   = 3'd4
  } reg_idx_t;

  localparam int CFG_DATA_W = 16;

  localparam logic signed [7:0] SAT_MAX   = 8'sd127;
  localparam logic signed [7:0] SAT_MIN   = -8'sd128;
  localparam logic signed [7:0] MASK_TRUE = -8'sd1;

  typedef struct packed {
    logic signed [15:0] scalar_value;
    logic signed [7:0]  multiplier_value;
    logic        [4:0]  shift_bits;
    logic signed [7:0]  ceiling_value;
    logic signed [7:0]  floor_value;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    scalar_value:     16'sd0,
    multiplier_value: 8'sd0,
    shift_bits:       5'd0,
    ceiling_value:    SAT_MAX,
    floor_value:      SAT_MIN
  };

endpackage

// ===== hdl/isva_in_if.sv =====
// input channel of the int8 vector alu: valid/ready plus one element item
// no dependencies
interface isva_in_if;
  logic               valid;
  logic               ready;
  logic        [4:0]  op;
  logic signed [7:0]  elem_a;
  logic signed [7:0]  elem_b;
  logic               first_elem;
  logic               last_elem;
  logic signed [31:0] start_value;

  modport source (output valid, op, elem_a, elem_b, first_elem, last_elem, start_value,
                  input ready);
  modport sink   (input valid, op, elem_a, elem_b, first_elem, last_elem, start_value,
                  output ready);
endinterface

// ===== hdl/isva_out_if.sv =====
// result channel of the int8 vector alu: valid/ready plus one 32-bit result
// no dependencies
interface isva_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;

  modport source (output valid, result_value, input ready);
  modport sink   (input valid, result_value, output ready);
endinterface

// ===== hdl/isva_alu.sv =====
// combinational datapath: element ops, shared multiplier and reduction adder
// depends on isva_pkg
module isva_alu (
  input  logic        [4:0]  op,
  input  logic signed [7:0]  elem_a,
  input  logic signed [7:0]  elem_b,
  input  logic               first_elem,
  input  logic               last_elem,
  input  logic signed [31:0] start_value,
  input  isva_pkg::cfg_t     cfg,
  input  logic        [31:0] acc,
  output logic signed [31:0] result_value,
  output logic               emit,
  output logic        [31:0] acc_nxt
);
  import isva_pkg::*;

  function automatic logic signed [7:0] sat8(input logic signed [16:0] v);
    logic signed [7:0] r;
    if (v > 17'sd127) begin
      r = SAT_MAX;
    end else if (v < -17'sd128) begin
      r = SAT_MIN;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  logic signed [15:0] mul_opnd;
  logic signed [23:0] prod;
  logic signed [23:0] prod_sh;
  logic signed [16:0] a_ext;
  logic signed [16:0] b_ext;
  logic signed [16:0] s_ext;
  logic signed [7:0]  neg_a;
  logic signed [7:0]  r8;
  logic        [31:0] term;
  logic        [31:0] base;
  logic               is_red;

  assign a_ext = {{9{elem_a[7]}}, elem_a};
  assign b_ext = {{9{elem_b[7]}}, elem_b};
  assign s_ext = {cfg.scalar_value[15], cfg.scalar_value};
  assign neg_a = -elem_a;

  // one multiplier serves every product; the second operand follows the op
  always_comb begin
    case (op)
      OP_MULSCALARSHIFT: mul_opnd = cfg.scalar_value;
      OP_RELU, OP_MAC:   mul_opnd = {{8{cfg.multiplier_value[7]}}, cfg.multiplier_value};
      default:           mul_opnd = {{8{elem_b[7]}}, elem_b};
    endcase
  end

  assign prod    = elem_a * mul_opnd;
  assign prod_sh = prod >>> cfg.shift_bits;

  assign is_red = (op == OP_DOT) || (op == OP_SUM) || (op == OP_MAC);

  // reduction term and base; dot and sum start from zero
  always_comb begin
    if (op == OP_SUM) begin
      term = {{24{elem_a[7]}}, elem_a};
    end else begin
      term = {{8{prod[23]}}, prod};
    end
    if (!first_elem) begin
      base = acc;
    end else if (op == OP_MAC) begin
      base = start_value;
    end else begin
      base = '0;
    end
    acc_nxt = is_red ? (base + term) : acc;
  end

  always_comb begin
    r8 = '0;
    unique case (op)
      OP_ADD:            r8 = sat8(a_ext + b_ext);
      OP_ADDSCALAR:      r8 = sat8(a_ext + s_ext);
      OP_SUB:            r8 = sat8(a_ext - b_ext);
      OP_ABS:            r8 = (elem_a == SAT_MIN) ? SAT_MAX : (elem_a[7] ? neg_a : elem_a);
      OP_NEG:            r8 = (elem_a == SAT_MIN) ? SAT_MAX : neg_a;
      OP_CEIL:           r8 = (elem_a > cfg.ceiling_value) ? cfg.ceiling_value : elem_a;
      OP_FLOOR:          r8 = (elem_a < cfg.floor_value) ? cfg.floor_value : elem_a;
      OP_EQ:             r8 = (elem_a == elem_b) ? MASK_TRUE : 8'sd0;
      OP_GT:             r8 = (elem_a > elem_b) ? MASK_TRUE : 8'sd0;
      OP_LT:             r8 = (elem_a < elem_b) ? MASK_TRUE : 8'sd0;
      OP_MULSHIFT,
      OP_MULSCALARSHIFT: r8 = prod_sh[7:0];
      OP_RELU:           r8 = (elem_a > 8'sd0) ? elem_a : prod_sh[7:0];
      default:           r8 = '0;
    endcase
  end

  always_comb begin
    if (is_red) begin
      result_value = acc_nxt;
      emit         = last_elem;
    end else if (op == OP_MULWIDE) begin
      result_value = {{16{prod[15]}}, prod[15:0]};
      emit         = 1'b1;
    end else begin
      result_value = {{24{r8[7]}}, r8};
      emit         = 1'b1;
    end
  end

endmodule

// ===== hdl/int8_saturating_vector_alu_top.sv =====
// an accepted item is held in the input register, then its result in the result register
// throughput: one item per cycle while the result side does not stall; input register, one alu pass, result register
// reductions hold a 32-bit running total and emit only on the last element
// reset (synchronous, rst_n low) empties both stages, clears the total and
// loads the configuration registers with their defaults
// depends on isva_pkg, isva_in_if, isva_out_if, isva_alu, assert_macros.svh
`include "assert_macros.svh"

module int8_saturating_vector_alu_top (
  input  logic                           clk,
  input  logic                           rst_n,
  isva_in_if.sink                        in_ch,
  isva_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  isva_pkg::reg_idx_t             cfg_index,
  input  logic [isva_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import isva_pkg::*;

  cfg_t               cfg_r;
  logic               s1_v_r;
  logic        [4:0]  s1_op_r;
  logic signed [7:0]  s1_a_r;
  logic signed [7:0]  s1_b_r;
  logic               s1_first_r;
  logic               s1_last_r;
  logic signed [31:0] s1_start_r;
  logic        [31:0] acc_r;
  logic        [31:0] acc_nxt;
  logic               out_v_r;
  logic signed [31:0] out_val_r;
  logic signed [31:0] alu_result;
  logic               alu_emit;
  logic               s1_fire;
  logic               in_accept;

  assign s1_fire      = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !s1_v_r || s1_fire;
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_v_r;
  assign out_ch.result_value = out_val_r;

  isva_alu u_alu (
    .op           (s1_op_r),
    .elem_a       (s1_a_r),
    .elem_b       (s1_b_r),
    .first_elem   (s1_first_r),
    .last_elem    (s1_last_r),
    .start_value  (s1_start_r),
    .cfg          (cfg_r),
    .acc          (acc_r),
    .result_value (alu_result),
    .emit         (alu_emit),
    .acc_nxt      (acc_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      acc_r   <= '0;
      cfg_r   <= CFG_RESET;
    end else begin
      if (in_ch.ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (s1_fire) begin
        acc_r   <= acc_nxt;
        out_v_r <= alu_emit;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SCALAR:  cfg_r.scalar_value     <= cfg_wdata;
          REG_MULT:    cfg_r.multiplier_value <= cfg_wdata[7:0];
          REG_SHIFT:   cfg_r.shift_bits       <= cfg_wdata[4:0];
          REG_CEILING: cfg_r.ceiling_value    <= cfg_wdata[7:0];
          REG_FLOOR:   cfg_r.floor_value      <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r    <= in_ch.op;
      s1_a_r     <= in_ch.elem_a;
      s1_b_r     <= in_ch.elem_b;
      s1_first_r <= in_ch.first_elem;
      s1_last_r  <= in_ch.last_elem;
      s1_start_r <= in_ch.start_value;
    end
    if (s1_fire && alu_emit) begin
      out_val_r <= alu_result;
    end
  end

  `ASSERT_CLK_ANY(a_reset_empties_out, !rst_n |=> !out_v_r, "result valid right after reset")
  `ASSERT_CLK(a_stall_cause, !in_ch.ready |-> (s1_v_r && out_v_r && !out_ch.ready), "input stalled without a full pipe")
  `ASSERT_CLK(a_no_spurious_result, (s1_fire && !alu_emit && !out_v_r) |=> !out_v_r, "result from a non-last reduction element")
  `ASSERT_CLK(a_total_holds, !(s1_fire && (s1_op_r == OP_DOT || s1_op_r == OP_SUM || s1_op_r == OP_MAC)) |=> $stable(acc_r), "running total moved without a reduction")

endmodule

// ===== verif/tb_int8_saturating_vector_alu_top.sv =====
// self-checking testbench for int8_saturating_vector_alu_top: a directed table, then random
// element ops and reduction runs under several register settings, checked by a predictor
// depends on isva_pkg, isva_in_if, isva_out_if and the top level rtl
`timescale 1ns / 1ps

module tb_int8_saturating_vector_alu_top;
  import isva_pkg::*;

  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int MAX_IDLE        = 16;
  localparam int DRAIN_CYCLES    = 4;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam logic [4:0] OP_SPARE_FIRST = 5'd18;
  localparam logic [4:0] OP_SPARE_LAST  = 5'd31;
  localparam logic [2:0] REG_IDX_SPARE  = 3'd5;

  typedef struct packed {
    logic [4:0]         op;
    logic signed [7:0]  elem_a;
    logic signed [7:0]  elem_b;
    logic               first_elem;
    logic               last_elem;
    logic signed [31:0] start_value;
  } elem_item_t;

  typedef struct packed {
    elem_item_t  item;
    logic        pinned;
    logic [31:0] pinned_value;
  } stim_row_t;

  localparam int NUM_DIRECTED = 26;

  // rows after reset: scalar 0, multiplier 0, shift 0, ceiling 127, floor -128
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{'{OP_ADD,            8'h7F, 8'h7F, 1'b0, 1'b0, 32'h0}, 1'b1, 32'd127},
    '{'{OP_ADD,            8'h80, 8'h80, 1'b0, 1'b0, 32'h0}, 1'b1, 32'hFFFF_FF80},
    '{'{OP_SUB,            8'h7F, 8'h80, 1'b0, 1'b0, 32'h0}, 1'b1, 32'd127},
    '{'{OP_SUB,            8'h80, 8'h7F, 1'b0, 1'b0, 32'h0}, 1'b1, 32'hFFFF_FF80},
    '{'{OP_ADDSCALAR,      8'h64, 8'h00, 1'b0, 1'b0, 32'h0}, 1'b0, 32'h0},
    '{'{OP_ABS,            8'h80, 8'h00, 1'b0, 1'b0, 32'h0}, 1'b1, 32'd127},
    '{'{OP_NEG,            8'h80, 8'h00, 1'b0, 1'b0, 32'h0}, 1'b1, 32'd127},
    '{'{OP_NEG,            8'h7F, 8'h11, 1'b0, 1'b0, 32'h0}, 1'b0, 32'h0},
    '{'{OP_CEIL,           8'h7F, 8'h00, 1'b0, 1'b0, 32'h0}, 1'b1, 32'd127},
    '{'{OP_FLOOR,          8'h80, 8'h00, 1'b0, 1'b0, 32'h0}, 1'b1, 32'hFFFF_FF80},
    '{'{OP_EQ,             8'h80, 8'h80, 1'b0, 1'b0, 32'h0}, 1'b1, 32'hFFFF_FFFF},
    '{'{OP_GT,             8'h7F, 8'h80, 1'b0, 1'b0, 32'h0}, 1'b1, 32'hFFFF_FFFF},
    '{'{OP_LT,             8'h7F, 8'h80, 1'b0, 1'b0, 32'h0}, 1'b1, 32'h0},
    '{'{OP_MULWIDE,        8'h80, 8'h80, 1'b0, 1'b0, 32'h0}, 1'b1, 32'd16384},
    '{'{OP_MULSHIFT,       8'h7F, 8'h7F, 1'b0, 1'b0, 32'h0}, 1'b0, 32'h0},
    '{'{OP_MULSCALARSHIFT, 8'h80, 8'h00, 1'b0, 1'b0, 32'h0}, 1'b1, 32'h0},
    '{'{OP_RELU,           8'h7F, 8'h00, 1'b0, 1'b0, 32'h0}, 1'b1, 32'd127},
    '{'{OP_RELU,           8'h80, 8'h00, 1'b0, 1'b0, 32'h0}, 1'b1, 32'h0},
    // dot run with no first mark builds on the cleared total
    '{'{OP_DOT,            8'h80, 8'h80, 1'b0, 1'b0, 32'h0}, 1'b0, 32'h0},
    '{'{OP_DOT,            8'hFF, 8'h01, 1'b0, 1'b1, 32'h0}, 1'b0, 32'h0},
    '{'{OP_SUM,            8'h80, 8'h00, 1'b1, 1'b1, 32'h0}, 1'b1, 32'hFFFF_FF80},
    '{'{OP_MAC,            8'h05, 8'h00, 1'b1, 1'b1, 32'h7FFF_FFFF}, 1'b1, 32'h7FFF_FFFF},
    '{'{OP_MAC,            8'h07, 8'h03, 1'b1, 1'b0, 32'h8000_0000}, 1'b0, 32'h0},
    '{'{OP_MAC,            8'hFD, 8'h00, 1'b0, 1'b1, 32'h1234_5678}, 1'b0, 32'h0},
    '{'{OP_ZERO,           8'h37, 8'h22, 1'b0, 1'b0, 32'h0}, 1'b1, 32'h0},
    '{'{OP_SPARE_LAST,     8'h7F, 8'h80, 1'b1, 1'b1, 32'hFFFF_FFFF}, 1'b1, 32'h0}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  reg_idx_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  isva_in_if  in_if ();
  isva_out_if out_if ();

  int8_saturating_vector_alu_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  cfg_t        reg_shadow;
  logic [31:0] running_sum;
  logic [31:0] expected_results [$];
  logic [31:0] want_value;
  int          error_count;
  int          quiet_cycles;
  bit          throttle_en;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int clamp_s8(input int v);
    if (v > SAT_MAX) return SAT_MAX;
    if (v < SAT_MIN) return SAT_MIN;
    return v;
  endfunction

  // arithmetic shift, then the low byte taken as signed
  function automatic int shift_low8(input int p, input int unsigned s);
    logic signed [7:0] q;
    q = 8'(p >>> s);
    return q;
  endfunction

  // returns 1 when the item produces a result; updates the running sum
  function automatic bit predict_result(input elem_item_t it, output logic [31:0] res);
    int a, b, sc, mul, ceil_v, floor_v, r;
    int unsigned sh;
    logic [31:0] term, base;
    a       = $signed(it.elem_a);
    b       = $signed(it.elem_b);
    sc      = $signed(reg_shadow.scalar_value);
    mul     = $signed(reg_shadow.multiplier_value);
    ceil_v  = $signed(reg_shadow.ceiling_value);
    floor_v = $signed(reg_shadow.floor_value);
    sh      = reg_shadow.shift_bits;
    r       = 0;
    res     = '0;
    case (it.op)
      OP_DOT, OP_SUM, OP_MAC: begin
        if (it.op == OP_DOT) begin
          term = a * b;
          base = '0;
        end else if (it.op == OP_SUM) begin
          term = a;
          base = '0;
        end else begin
          term = a * mul;
          base = it.start_value;
        end
        running_sum = (it.first_elem ? base : running_sum) + term;
        res = running_sum;
        return it.last_elem;
      end
      OP_ADD:            r = clamp_s8(a + b);
      OP_ADDSCALAR:      r = clamp_s8(a + sc);
      OP_SUB:            r = clamp_s8(a - b);
      OP_ABS:            r = (a == SAT_MIN) ? SAT_MAX : ((a < 0) ? -a : a);
      OP_NEG:            r = (a == SAT_MIN) ? SAT_MAX : -a;
      OP_CEIL:           r = (a > ceil_v) ? ceil_v : a;
      OP_FLOOR:          r = (a < floor_v) ? floor_v : a;
      OP_EQ:             r = (a == b) ? MASK_TRUE : 0;
      OP_GT:             r = (a > b) ? MASK_TRUE : 0;
      OP_LT:             r = (a < b) ? MASK_TRUE : 0;
      OP_MULWIDE:        r = a * b;
      OP_MULSHIFT:       r = shift_low8(a * b, sh);
      OP_MULSCALARSHIFT: r = shift_low8(a * sc, sh);
      OP_RELU:           r = (a > 0) ? a : shift_low8(a * mul, sh);
      default:           r = 0;
    endcase
    res = r;
    return 1'b1;
  endfunction

  function automatic logic signed [7:0] pick_elem();
    case ($urandom_range(7, 0))
      0:       return SAT_MIN;
      1:       return SAT_MAX;
      2:       return 8'sd0;
      3:       return MASK_TRUE;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic elem_item_t random_item(input logic [4:0] op);
    elem_item_t it;
    it.op          = op;
    it.elem_a      = pick_elem();
    it.elem_b      = pick_elem();
    it.first_elem  = 1'b0;
    it.last_elem   = 1'b0;
    it.start_value = ($urandom_range(3, 0) == 0) ? 32'sh8000_0000 : 32'($urandom);
    return it;
  endfunction

  function automatic logic [4:0] pick_reduction_op();
    case ($urandom_range(2, 0))
      0:       return OP_DOT;
      1:       return OP_SUM;
      default: return OP_MAC;
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= reg_idx_t'(idx);
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SCALAR:  reg_shadow.scalar_value     = data;
      REG_MULT:    reg_shadow.multiplier_value = data[7:0];
      REG_SHIFT:   reg_shadow.shift_bits       = data[4:0];
      REG_CEILING: reg_shadow.ceiling_value    = data[7:0];
      REG_FLOOR:   reg_shadow.floor_value      = data[7:0];
      default:     ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_item(input elem_item_t it, input bit pinned,
                           input logic [31:0] pinned_value);
    int gap;
    logic [31:0] predicted;
    gap = throttle_en ? $urandom_range(MAX_IDLE, 0) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.op          <= it.op;
    in_if.elem_a      <= it.elem_a;
    in_if.elem_b      <= it.elem_b;
    in_if.first_elem  <= it.first_elem;
    in_if.last_elem   <= it.last_elem;
    in_if.start_value <= it.start_value;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (predict_result(it, predicted))
      expected_results.push_back(pinned ? pinned_value : predicted);
  endtask

  // reductions without a last mark leave work in flight, so linger past the last result
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result side: stalls drawn per transaction
  initial begin : result_sink
    int stall;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = throttle_en ? $urandom_range(MAX_IDLE, 0) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing pending", out_if.result_value));
      end else begin
        want_value = expected_results.pop_front();
        if (out_if.result_value !== want_value)
          report_mismatch($sformatf("result_value got %h want %h",
                                    out_if.result_value, want_value));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] TIMEOUT: no transaction for %0d cycles", $realtime, quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : main
    elem_item_t it;
    int phase, sent, len, pick;
    logic [4:0] op;
    logic [CFG_DATA_W-1:0] v_scalar, v_mult, v_shift, v_ceil, v_floor;

    error_count  = 0;
    quiet_cycles = 0;
    throttle_en  = 1'b1;
    reg_shadow   = CFG_RESET;
    running_sum  = '0;

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_SCALAR;
    cfg_wdata         <= '0;
    in_if.valid       <= 1'b0;
    in_if.op          <= OP_ADD;
    in_if.elem_a      <= '0;
    in_if.elem_b      <= '0;
    in_if.first_elem  <= 1'b0;
    in_if.last_elem   <= 1'b0;
    in_if.start_value <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_item(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].pinned_value);
    wait_idle();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          v_scalar = 16'h8000; v_mult = 16'h0080; v_shift = 16'h001F;
          v_ceil   = 16'h0080; v_floor = 16'h007F;
        end
        1: begin
          v_scalar = 16'h7FFF; v_mult = 16'h007F; v_shift = 16'h0000;
          v_ceil   = 16'h007F; v_floor = 16'h0080;
        end
        default: begin
          // odd phases keep the scalar near zero so add-scalar does not always saturate
          v_scalar = (phase % 2) ? 16'($urandom_range(300, 0) - 150) : 16'($urandom);
          v_mult   = 16'($urandom);
          v_shift  = (phase % 2) ? 16'($urandom_range(7, 0)) : 16'($urandom);
          v_ceil   = 16'($urandom);
          v_floor  = 16'($urandom);
        end
      endcase
      write_reg(REG_SCALAR, v_scalar);
      write_reg(REG_MULT, v_mult);
      write_reg(REG_SHIFT, v_shift);
      write_reg(REG_CEILING, v_ceil);
      write_reg(REG_FLOOR, v_floor);
      if (phase == 2)
        write_reg(REG_IDX_SPARE, 16'($urandom));

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        throttle_en = ($urandom_range(4, 0) != 0);
        pick = $urandom_range(9, 0);
        if (pick < 4) begin
          // well-formed reduction run
          len = $urandom_range(8, 1);
          op  = pick_reduction_op();
          for (int k = 0; k < len; k++) begin
            it = random_item(op);
            it.first_elem = (k == 0);
            it.last_elem  = (k == len - 1);
            send_item(it, 1'b0, '0);
          end
          sent += len;
        end else if (pick < 9) begin
          pick = $urandom_range(OP_RELU + 2, 0);
          if (pick <= OP_RELU)
            op = 5'(pick);
          else if (pick == OP_RELU + 1)
            op = OP_ZERO;
          else
            op = 5'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
          it = random_item(op);
          it.first_elem = 1'($urandom_range(1, 0));
          it.last_elem  = 1'($urandom_range(1, 0));
          send_item(it, 1'b0, '0);
          sent++;
        end else begin
          // stray reduction element with arbitrary marks
          it = random_item(pick_reduction_op());
          it.first_elem = 1'($urandom_range(1, 0));
          it.last_elem  = 1'($urandom_range(1, 0));
          send_item(it, 1'b0, '0);
          sent++;
        end
      end
      throttle_en = 1'b1;
      wait_idle();
    end

    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/isva_pkg.sv
hdl/isva_in_if.sv
hdl/isva_out_if.sv
hdl/isva_alu.sv
hdl/int8_saturating_vector_alu_top.sv
verif/tb_int8_saturating_vector_alu_top.sv
